[sv/b64d_pkg.sv]
// Shared types, constants and the character classifier for the Base64 decoder.
// No dependencies; imported by every module of the decoder.
package b64d_pkg;

  localparam logic [7:0] PAD_CHAR = 8'h3D;
  localparam logic [7:0] END_CHAR = 8'h23;
  localparam int GROUP_BITS = 24;

  // One decode job passed from the front to the back.
  typedef struct packed {
    logic [GROUP_BITS-1:0] word;   // bytes, most significant first
    logic [1:0]            count;  // bytes to emit, 1 to 3
    logic                  term;   // terminator job
  } job_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic       valid;
    logic [5:0] value;
  } sextet_t;

  // Map a character to its sextet; padding counts as zero.
  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t s;
    s.valid = 1'b1;
    s.value = 6'd0;
    if (c >= 8'h41 && c <= 8'h5A) begin
      s.value = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7A) begin
      s.value = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      s.value = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2B) begin
      s.value = 6'd62;
    end else if (c == 8'h2F) begin
      s.value = 6'd63;
    end else if (c == PAD_CHAR) begin
      s.value = 6'd0;
    end else begin
      s.valid = 1'b0;
    end
    return s;
  endfunction

  // Number of bytes before the first zero byte of a group.
  function automatic logic [1:0] byte_count(input logic [GROUP_BITS-1:0] w);
    logic [1:0] n;
    if (w[23:16] == 8'd0) begin
      n = 2'd0;
    end else if (w[15:8] == 8'd0) begin
      n = 2'd1;
    end else if (w[7:0] == 8'd0) begin
      n = 2'd2;
    end else begin
      n = 2'd3;
    end
    return n;
  endfunction

endpackage

[sv/b64d_front.sv]
// Front end of the Base64 decoder: classifies characters and collects groups.
// Depends on b64d_pkg; pushes completed decode jobs into b64d_queue.
module b64d_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  logic [7:0]     in_char,
  input  logic           end_of_line,
  output logic           job_push,
  output b64d_pkg::job_t job
);
  import b64d_pkg::*;

  logic [17:0] group_bits;
  logic [17:0] group_bits_next;
  logic [1:0]  group_count;
  logic [1:0]  group_count_next;
  logic        halted;
  logic        halted_next;
  sextet_t     s;
  logic [23:0] word;
  logic        have_word;
  logic [1:0]  n_bytes;

  assign s = sextet_of(in_char);

  // Group assembly, end-of-line flush and terminator handling.
  always_comb begin
    group_bits_next  = group_bits;
    group_count_next = group_count;
    halted_next      = halted;
    word             = 24'd0;
    have_word        = 1'b0;
    n_bytes          = 2'd0;
    job_push         = 1'b0;
    job.word         = 24'd0;
    job.count        = 2'd0;
    job.term         = 1'b0;
    if (accept && !halted) begin
      if (in_char == END_CHAR) begin
        group_bits_next  = 18'd0;
        group_count_next = 2'd0;
        halted_next      = 1'b1;
        job_push         = 1'b1;
        job.word         = {END_CHAR, 16'd0};
        job.count        = 2'd1;
        job.term         = 1'b1;
      end else begin
        if (s.valid) begin
          if (group_count == 2'd3) begin
            word             = {group_bits, s.value};
            have_word        = 1'b1;
            group_bits_next  = 18'd0;
            group_count_next = 2'd0;
          end else begin
            group_bits_next  = {group_bits[11:0], s.value};
            group_count_next = group_count + 2'd1;
          end
        end
        // Pad a pending partial group with zero sextets.
        if (end_of_line && group_count_next != 2'd0) begin
          have_word = 1'b1;
          case (group_count_next)
            2'd1:    word = {group_bits_next[5:0], 18'd0};
            2'd2:    word = {group_bits_next[11:0], 12'd0};
            default: word = {group_bits_next, 6'd0};
          endcase
          group_bits_next  = 18'd0;
          group_count_next = 2'd0;
        end
        n_bytes   = byte_count(word);
        job.word  = word;
        job.count = n_bytes;
        job_push  = have_word && (n_bytes != 2'd0);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      group_bits  <= 18'd0;
      group_count <= 2'd0;
      halted      <= 1'b0;
    end else begin
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      halted      <= halted_next;
    end
  end

endmodule

[sv/b64d_queue.sv]
// Short job queue between the front and back of the Base64 decoder.
// Depends on b64d_pkg for the job type; used by base64_stream_decoder.
module b64d_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  b64d_pkg::job_t    push_job,
  input  logic              pop,
  output b64d_pkg::job_t    head,
  output b64d_pkg::q_status_t status
);
  import b64d_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] fill;
  logic          do_push;
  logic          do_pop;

  assign status.empty = (fill == CW'(0));
  assign status.full  = (fill == CW'(DEPTH));
  assign do_push = push && !status.full;
  assign do_pop  = pop && !status.empty;
  assign head = entries[rd_ptr];

  // Storage writes.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + CW'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

[sv/b64d_back.sv]
// Back end of the Base64 decoder: emits job bytes one per cycle while popped.
// Depends on b64d_pkg; reads jobs from b64d_queue into an output register.
module b64d_back (
  input  logic                clk,
  input  logic                rst,
  input  b64d_pkg::job_t      head,
  input  b64d_pkg::q_status_t status,
  output logic                job_pop,
  input  logic                pop,
  output logic                empty,
  output logic [7:0]          out_byte,
  output logic                end_mark,
  output logic                last
);
  import b64d_pkg::*;

  logic [1:0] idx;
  logic       out_valid;
  logic       load;
  logic       take;
  logic       is_last;
  logic [7:0] sel_byte;

  assign empty   = !out_valid;
  assign load    = !out_valid || pop;
  assign take    = load && !status.empty;
  assign is_last = (idx == head.count - 2'd1);
  assign job_pop = take && is_last;

  // Pick the current byte of the head job.
  always_comb begin
    case (idx)
      2'd0:    sel_byte = head.word[23:16];
      2'd1:    sel_byte = head.word[15:8];
      default: sel_byte = head.word[7:0];
    endcase
  end

  // Output register payload.
  always_ff @(posedge clk) begin
    if (take) begin
      out_byte <= sel_byte;
      end_mark <= head.term;
      last     <= is_last;
    end
  end

  // Output valid flag and byte index.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      if (load) begin
        out_valid <= !status.empty;
      end
      if (take) begin
        idx <= is_last ? 2'd0 : idx + 2'd1;
      end
    end
  end

endmodule

[sv/base64_stream_decoder.sv]
// Streaming Base64 decoder: one character in per cycle while full is low,
// bytes out as a queue through the job queue and the output register.
// Throughput: one byte leaves per cycle while the reader pops, so full rises
// only while decoded bytes outpace the reader and the job queue fills.
// Reset (synchronous rst): clears the partial group, halt flag, queue and output.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
module base64_stream_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_char,
  input  logic       end_of_line,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       end_mark,
  output logic       last
);
  import b64d_pkg::*;

  job_t      new_job;
  job_t      head_job;
  logic      job_push;
  logic      job_pop;
  q_status_t q_status;

  assign full = q_status.full;

  // Front: classification and group assembly.
  b64d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (push && !full),
    .in_char     (in_char),
    .end_of_line (end_of_line),
    .job_push    (job_push),
    .job         (new_job)
  );

  // Job queue decoupling the two sides.
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (job_push),
    .push_job (new_job),
    .pop      (job_pop),
    .head     (head_job),
    .status   (q_status)
  );

  // Back: byte emission.
  b64d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head_job),
    .status   (q_status),
    .job_pop  (job_pop),
    .pop      (pop),
    .empty    (empty),
    .out_byte (out_byte),
    .end_mark (end_mark),
    .last     (last)
  );

endmodule
